// File: sv/irh_pkg.sv
// Shared types and constants for the incremental rehash hash table.
`default_nettype none
package irh_pkg;
	localparam int NODE_W = 12;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 13;
	localparam int LF_W   = 3;
	localparam int RW_W   = 10;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_POP    = 2'd2;

	localparam logic REG_LOAD_FACTOR = 1'b0;
	localparam logic REG_RESIZE_WORK = 1'b1;

	localparam logic [LF_W-1:0] LF_RESET = 3'd3;
	localparam logic [RW_W-1:0] RW_RESET = 10'd128;

	typedef struct packed {
		logic next_we;
		logic hk_we;
	} node_we_t;
endpackage
`default_nettype wire

// File: sv/irh_head_ram.sv
// Bucket head memory for both banks, one write and one registered read port.
`default_nettype none
module irh_head_ram #(
	parameter int AW = 13,
	parameter int DW = 13
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/irh_node_ram.sv
// Node store: next link, hash and key per node slot.
`default_nettype none
module irh_node_ram #(
	parameter int DEPTH = 4096,
	parameter int IW    = 12
) (
	input  wire logic                    clk,
	input  wire irh_pkg::node_we_t       we,
	input  wire logic [IW-1:0]           waddr,
	input  wire logic [IW:0]             wnext,
	input  wire logic [irh_pkg::WORD_W-1:0] whash,
	input  wire logic [irh_pkg::WORD_W-1:0] wkey,
	input  wire logic                    re,
	input  wire logic [IW-1:0]           raddr,
	output logic      [IW:0]             rnext,
	output logic      [irh_pkg::WORD_W-1:0] rhash,
	output logic      [irh_pkg::WORD_W-1:0] rkey
);
	import irh_pkg::*;

	logic [IW:0]       next_mem [DEPTH];
	logic [WORD_W-1:0] hash_mem [DEPTH];
	logic [WORD_W-1:0] key_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (we.next_we) begin
			next_mem[waddr] <= wnext;
		end
		if (we.hk_we) begin
			hash_mem[waddr] <= whash;
			key_mem[waddr]  <= wkey;
		end
		if (re) begin
			rnext <= next_mem[raddr];
			rhash <= hash_mem[raddr];
			rkey  <= key_mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/incremental_rehash_hash_table.sv
// Top level: chained hash table sequencer with incremental rehash.
//  channel | signals                                   | transaction
//  req     | req_valid req_stall kind node hash key    | one operation
//  rsp     | rsp_valid rsp_stall found match_node       | one result
//          | entry_count                               |
//  cfg     | psel penable pwrite paddr pwdata prdata   | register access
// Each head or node access is registered; an operation also migrates nodes while a resize
// runs, skips empty secondary slots, walks the chain it searches, searches the secondary
// when the primary misses, and clears the old bank when a migration ends.
// After reset a clearing pass over all 2*SLOTS_PER_TABLE head slots runs before req is taken.
// req is taken only while the sequencer is idle; a result waits in the rsp register.
`default_nettype none
module incremental_rehash_hash_table #(
	parameter int SLOTS_PER_TABLE = 4096,
	parameter int NODE_SLOTS      = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [irh_pkg::NODE_W-1:0] node,
	input  wire logic [irh_pkg::WORD_W-1:0] hash,
	input  wire logic [irh_pkg::WORD_W-1:0] key,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             found,
	output logic [irh_pkg::NODE_W-1:0] match_node,
	output logic [irh_pkg::CNT_W-1:0]  entry_count,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import irh_pkg::*;

	localparam int SW  = $clog2(SLOTS_PER_TABLE);
	localparam int AW  = SW + 1;
	localparam int NW  = $clog2(NODE_SLOTS);
	localparam int HW  = NW + 1;
	localparam int LGW = $clog2(SW + 1);
	localparam logic [HW-1:0] NIL = {1'b1, {NW{1'b0}}};

	localparam logic [4:0] ST_INIT  = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_I_HD  = 5'd2;
	localparam logic [4:0] ST_I_LK  = 5'd3;
	localparam logic [4:0] ST_I_RS  = 5'd4;
	localparam logic [4:0] ST_M_CHK = 5'd5;
	localparam logic [4:0] ST_M_HD  = 5'd6;
	localparam logic [4:0] ST_M_NX  = 5'd7;
	localparam logic [4:0] ST_M_LK  = 5'd8;
	localparam logic [4:0] ST_M_END = 5'd9;
	localparam logic [4:0] ST_CLR   = 5'd10;
	localparam logic [4:0] ST_S_HD  = 5'd11;
	localparam logic [4:0] ST_S_HW  = 5'd12;
	localparam logic [4:0] ST_S_CUR = 5'd13;
	localparam logic [4:0] ST_S_ND  = 5'd14;
	localparam logic [4:0] ST_DONE  = 5'd15;

	logic [4:0]        state_q;
	logic [LF_W-1:0]   lf_q;
	logic [RW_W-1:0]   rw_q;
	logic [1:0]        op_q;
	logic [NW-1:0]     node_q;
	logic [WORD_W-1:0] hash_q, key_q;
	logic              pb_q, plive_q, slive_q, sec_q;
	logic [LGW-1:0]    plg_q, slg_q;
	logic [CNT_W-1:0]  pcnt_q, scnt_q;
	logic [AW-1:0]     mslot_q, clr_q, clr_last_q;
	logic [RW_W-1:0]   moved_q;
	logic [NW-1:0]     mn_q;
	logic [SW-1:0]     spos_q;
	logic [HW-1:0]     cur_q, prev_q;
	logic [NW:0]       steps_q;
	logic              res_found_q;
	logic [NODE_W-1:0] res_match_q;
	logic              rsp_valid_q, found_q;
	logic [NODE_W-1:0] match_q;
	logic [CNT_W-1:0]  count_q;

	logic              hwe, hre;
	logic [AW-1:0]     hwaddr, hraddr;
	logic [HW-1:0]     hwdata, hrd;
	node_we_t          nwe;
	logic              nre;
	logic [NW-1:0]     nwaddr, nraddr;
	logic [HW-1:0]     nwnext, nrnext;
	logic [WORD_W-1:0] nwhash, nwkey, nrhash, nrkey;

	logic [31:0]       node32;
	logic              node_ok, accept, hit, sbank, rsp_free, mig_go, mig_end;
	logic [AW-1:0]     slots_s;
	logic [31:0]       need32, trig_lim;
	logic [LGW-1:0]    lg_new;
	logic [4:0]        after_mig;

	function automatic logic [SW-1:0] pos_of(input logic [WORD_W-1:0] h,
		input logic [LGW-1:0] lg);
		logic [SW-1:0] mask;
		mask = ~({SW{1'b1}} << lg);
		return h[SW-1:0] & mask;
	endfunction

	assign node32    = {{(32-NODE_W){1'b0}}, node};
	assign node_ok   = node32 < 32'(NODE_SLOTS);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign hit       = (nrhash == hash_q) && (nrkey == key_q);
	assign sbank     = sec_q ? ~pb_q : pb_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign slots_s   = AW'(1) << slg_q;
	assign mig_go    = (moved_q < rw_q) && (scnt_q != '0) && (mslot_q < slots_s);
	assign mig_end   = (scnt_q == '0) || (mslot_q >= slots_s);
	assign after_mig = (op_q == KIND_INSERT || !plive_q) ? ST_DONE : ST_S_HD;
	assign need32    = {{(31-CNT_W){1'b0}}, pcnt_q, 1'b0};
	assign trig_lim  = 32'd1 << (int'(plg_q) + int'(lf_q));

	always_comb begin
		lg_new = LGW'(SW);
		for (int i = SW; i >= 0; i--) begin
			if ((32'd1 << i) >= need32) lg_new = LGW'(i);
		end
	end

	always_comb begin
		hwe = 1'b0; hwaddr = clr_q; hwdata = NIL;
		hre = 1'b0; hraddr = {pb_q, pos_of(hash_q, plg_q)};
		nwe = '0; nwaddr = node_q; nwnext = hrd; nwhash = hash_q; nwkey = key_q;
		nre = 1'b0; nraddr = cur_q[NW-1:0];
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				hwe = 1'b1;
			end
			ST_I_HD: begin
				nwe.hk_we = 1'b1;
				hre = 1'b1;
			end
			ST_I_LK: begin
				nwe.next_we = 1'b1;
				hwe = 1'b1; hwaddr = {pb_q, spos_q}; hwdata = {1'b0, node_q};
			end
			ST_M_CHK: begin
				hre = 1'b1; hraddr = {~pb_q, mslot_q[SW-1:0]};
			end
			ST_M_HD: begin
				nre = 1'b1; nraddr = hrd[NW-1:0];
			end
			ST_M_NX: begin
				hwe = 1'b1; hwaddr = {~pb_q, mslot_q[SW-1:0]}; hwdata = nrnext;
				hre = 1'b1; hraddr = {pb_q, pos_of(nrhash, plg_q)};
			end
			ST_M_LK: begin
				nwe.next_we = 1'b1; nwaddr = mn_q;
				hwe = 1'b1; hwaddr = {pb_q, spos_q}; hwdata = {1'b0, mn_q};
			end
			ST_S_HD: begin
				hre = 1'b1;
				hraddr = {sbank, pos_of(hash_q, sec_q ? slg_q : plg_q)};
			end
			ST_S_CUR: begin
				nre = 1'b1;
			end
			ST_S_ND: begin
				if (hit && op_q == KIND_POP) begin
					if (prev_q[NW]) begin
						hwe = 1'b1; hwaddr = {sbank, spos_q}; hwdata = nrnext;
					end else begin
						nwe.next_we = 1'b1; nwaddr = prev_q[NW-1:0]; nwnext = nrnext;
					end
				end
			end
			default: begin
			end
		endcase
	end

	irh_head_ram #(.AW(AW), .DW(HW)) u_heads (
		.clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata),
		.re(hre), .raddr(hraddr), .rdata(hrd)
	);

	irh_node_ram #(.DEPTH(NODE_SLOTS), .IW(NW)) u_nodes (
		.clk(clk), .we(nwe), .waddr(nwaddr), .wnext(nwnext), .whash(nwhash),
		.wkey(nwkey), .re(nre), .raddr(nraddr), .rnext(nrnext), .rhash(nrhash),
		.rkey(nrkey)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lf_q <= LF_RESET;
			rw_q <= RW_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_LOAD_FACTOR: lf_q <= pwdata[LF_W-1:0];
				REG_RESIZE_WORK: rw_q <= pwdata[RW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign prdata = paddr[2] ? {{(32-RW_W){1'b0}}, rw_q} : {{(32-LF_W){1'b0}}, lf_q};
	assign pready = 1'b1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= kind;
			node_q <= node32[NW-1:0];
			hash_q <= hash;
			key_q  <= key;
			res_found_q <= 1'b0;
			res_match_q <= (kind == KIND_INSERT) ? node : '0;
			moved_q <= '0;
			sec_q   <= 1'b0;
		end
		unique case (state_q)
			ST_I_HD: spos_q <= pos_of(hash_q, plg_q);
			ST_M_HD: mn_q <= hrd[NW-1:0];
			ST_M_NX: spos_q <= pos_of(nrhash, plg_q);
			ST_M_LK: moved_q <= moved_q + 1'b1;
			ST_S_HD: begin
				spos_q  <= pos_of(hash_q, sec_q ? slg_q : plg_q);
				prev_q  <= NIL;
				steps_q <= '0;
			end
			ST_S_HW: cur_q <= hrd;
			ST_S_CUR: begin
				if (!(!cur_q[NW] && steps_q < (NW+1)'(NODE_SLOTS)) && !sec_q && slive_q) begin
					sec_q <= 1'b1;
				end
			end
			ST_S_ND: begin
				if (hit) begin
					res_found_q <= 1'b1;
					res_match_q <= NODE_W'(cur_q[NW-1:0]);
				end else begin
					prev_q  <= cur_q;
					cur_q   <= nrnext;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && rsp_free) begin
			found_q <= res_found_q;
			match_q <= res_match_q;
			count_q <= pcnt_q + scnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			clr_q      <= '0;
			clr_last_q <= '1;
			pb_q       <= 1'b0;
			plive_q    <= 1'b0;
			slive_q    <= 1'b0;
			plg_q      <= LGW'(2);
			slg_q      <= '0;
			pcnt_q     <= '0;
			scnt_q     <= '0;
			mslot_q    <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == clr_last_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_INSERT) begin
							if (node_ok) begin
								plive_q <= 1'b1;
								state_q <= ST_I_HD;
							end else begin
								state_q <= ST_DONE;
							end
						end else if (kind == KIND_LOOKUP || kind == KIND_POP) begin
							state_q <= ST_M_CHK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_I_HD: state_q <= ST_I_LK;
				ST_I_LK: begin
					pcnt_q  <= pcnt_q + 1'b1;
					state_q <= ST_I_RS;
				end
				ST_I_RS: begin
					if (!slive_q && ({{(32-CNT_W){1'b0}}, pcnt_q} >= trig_lim) &&
						(need32 <= 32'(SLOTS_PER_TABLE))) begin
						slive_q <= 1'b1;
						slg_q   <= plg_q;
						scnt_q  <= pcnt_q;
						pb_q    <= ~pb_q;
						plg_q   <= lg_new;
						pcnt_q  <= '0;
						mslot_q <= '0;
					end
					state_q <= ST_M_CHK;
				end
				ST_M_CHK: begin
					if (!slive_q) state_q <= after_mig;
					else if (mig_go) state_q <= ST_M_HD;
					else state_q <= ST_M_END;
				end
				ST_M_HD: begin
					if (hrd[NW]) begin
						mslot_q <= mslot_q + 1'b1;
						state_q <= ST_M_CHK;
					end else begin
						state_q <= ST_M_NX;
					end
				end
				ST_M_NX: begin
					scnt_q  <= scnt_q - 1'b1;
					state_q <= ST_M_LK;
				end
				ST_M_LK: begin
					pcnt_q  <= pcnt_q + 1'b1;
					state_q <= ST_M_CHK;
				end
				ST_M_END: begin
					if (mig_end) begin
						slive_q    <= 1'b0;
						scnt_q     <= '0;
						slg_q      <= '0;
						mslot_q    <= '0;
						clr_q      <= {~pb_q, {SW{1'b0}}};
						clr_last_q <= {~pb_q, slots_s[SW-1:0] - 1'b1};
						state_q    <= ST_CLR;
					end else begin
						state_q <= after_mig;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == clr_last_q) state_q <= after_mig;
				end
				ST_S_HD: state_q <= ST_S_HW;
				ST_S_HW: state_q <= ST_S_CUR;
				ST_S_CUR: begin
					if (!cur_q[NW] && steps_q < (NW+1)'(NODE_SLOTS)) state_q <= ST_S_ND;
					else if (!sec_q && slive_q) state_q <= ST_S_HD;
					else state_q <= ST_DONE;
				end
				ST_S_ND: begin
					if (hit) begin
						if (op_q == KIND_POP) begin
							if (sec_q) scnt_q <= scnt_q - 1'b1;
							else pcnt_q <= pcnt_q - 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_S_CUR;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = found_q;
	assign match_node  = match_q;
	assign entry_count = count_q;
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the incremental rehash hash table.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import irh_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned TBL_SLOTS = 4096;
	localparam int unsigned NODES = 4096;
	localparam int unsigned NIL = 32'hFFFF_FFFF;

	typedef struct packed {
		logic              found;
		logic [NODE_W-1:0] node;
		logic [CNT_W-1:0]  cnt;
	} result_t;

	typedef struct {
		logic [1:0]        kind;
		logic [NODE_W-1:0] node;
		logic [WORD_W-1:0] hash;
		logic [WORD_W-1:0] key;
		bit                typed;
		result_t           res;
	} op_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        kind = '0;
	logic [NODE_W-1:0] node = '0;
	logic [WORD_W-1:0] hash = '0;
	logic [WORD_W-1:0] key = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              found;
	logic [NODE_W-1:0] match_node;
	logic [CNT_W-1:0]  entry_count;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	incremental_rehash_hash_table u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .node(node), .hash(hash), .key(key),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.found(found), .match_node(match_node), .entry_count(entry_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table shadow
	int unsigned heads[2*TBL_SLOTS];
	int unsigned nnext[NODES];
	int unsigned nhash[NODES];
	int unsigned nkey[NODES];
	int unsigned pbank, plive, slive, plg, slg, mslot;
	logic [CNT_W-1:0] pcnt, scnt;
	int unsigned cfg_lf = 3;
	int unsigned cfg_rw = 128;

	result_t expected_results[$];
	int errors = 0;
	bit burst = 1'b0;

	int unsigned live_nodes[$];
	bit in_table[NODES];
	int unsigned live_hash[NODES];
	int unsigned live_key[NODES];

	function automatic void tbl_clear(int unsigned b);
		for (int unsigned i = 0; i < TBL_SLOTS; i++)
			heads[(b & 1) * TBL_SLOTS + i] = NIL;
	endfunction

	function automatic void tbl_link(int unsigned n);
		int unsigned idx;
		idx = pbank * TBL_SLOTS + (nhash[n] & ((1 << plg) - 1));
		nnext[n] = heads[idx];
		heads[idx] = n;
		pcnt = pcnt + 1'b1;
	endfunction

	function automatic void tbl_migrate();
		int unsigned moved, n, idx, base;
		moved = 0;
		if (!slive)
			return;
		base = (pbank ^ 1) * TBL_SLOTS;
		while (moved < cfg_rw && scnt != 0 && mslot < (1 << slg)) begin
			idx = base + mslot;
			n = heads[idx];
			if (n >= NODES) begin
				mslot++;
				continue;
			end
			heads[idx] = nnext[n];
			scnt = scnt - 1'b1;
			tbl_link(n);
			moved++;
		end
		if (scnt == 0 || mslot >= (1 << slg)) begin
			slive = 0;
			scnt = '0;
			slg = 0;
			mslot = 0;
			tbl_clear(pbank ^ 1);
		end
	endfunction

	function automatic int unsigned tbl_search(int unsigned b, int unsigned lg,
			int unsigned h, int unsigned k, output int unsigned prev);
		int unsigned cur, steps;
		cur = heads[b * TBL_SLOTS + (h & ((1 << lg) - 1))];
		steps = 0;
		prev = NIL;
		while (cur < NODES && steps < NODES) begin
			if (nhash[cur] == h && nkey[cur] == k)
				return cur;
			prev = cur;
			cur = nnext[cur];
			steps++;
		end
		return NIL;
	endfunction

	function automatic void tbl_start_resize();
		int unsigned need, lg;
		need = 2 * int'(pcnt);
		lg = 0;
		while (lg < 31 && (1 << lg) < need)
			lg++;
		if ((1 << lg) > TBL_SLOTS)
			return;
		slive = 1;
		slg = plg;
		scnt = pcnt;
		pbank = pbank ^ 1;
		plg = lg;
		pcnt = '0;
		mslot = 0;
		tbl_clear(pbank);
	endfunction

	function automatic result_t tbl_step(logic [1:0] k, int unsigned n,
			int unsigned h, int unsigned ky);
		result_t r;
		int unsigned prev, b, hit, lg;
		r.found = 1'b0;
		r.node = '0;
		if (k == KIND_INSERT) begin
			r.node = NODE_W'(n);
			if (!plive) begin
				plive = 1;
				plg = 2;
				pcnt = '0;
				tbl_clear(pbank);
			end
			nhash[n] = h;
			nkey[n] = ky;
			tbl_link(n);
			if (!slive && int'(pcnt) >= ((1 << plg) << cfg_lf))
				tbl_start_resize();
			tbl_migrate();
		end else if (k == KIND_LOOKUP || k == KIND_POP) begin
			tbl_migrate();
			if (plive) begin
				b = pbank;
				hit = tbl_search(b, plg, h, ky, prev);
				if (hit == NIL && slive) begin
					b = pbank ^ 1;
					hit = tbl_search(b, slg, h, ky, prev);
				end
				if (hit != NIL) begin
					r.found = 1'b1;
					r.node = NODE_W'(hit);
					if (k == KIND_POP) begin
						lg = (b == pbank) ? plg : slg;
						if (prev == NIL)
							heads[b * TBL_SLOTS + (h & ((1 << lg) - 1))] = nnext[hit];
						else
							nnext[prev] = nnext[hit];
						if (b == pbank)
							pcnt = pcnt - 1'b1;
						else
							scnt = scnt - 1'b1;
					end
				end
			end
		end
		r.cnt = pcnt + scnt;
		return r;
	endfunction

	task automatic send_op(op_row_t row);
		result_t pred;
		int gap, idx[$];
		pred = tbl_step(row.kind, row.node, row.hash, row.key);
		if (row.kind == KIND_INSERT && !in_table[row.node]) begin
			in_table[row.node] = 1;
			live_nodes.push_back(row.node);
			live_hash[row.node] = row.hash;
			live_key[row.node] = row.key;
		end else if (row.kind == KIND_POP && pred.found) begin
			in_table[pred.node] = 0;
			idx = live_nodes.find_first_index(x) with (x == pred.node);
			if (idx.size() != 0)
				live_nodes.delete(idx[0]);
		end
		expected_results.push_back(row.typed ? row.res : pred);
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= row.kind;
		node <= row.node;
		hash <= row.hash;
		key <= row.key;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic apb_write(logic idx, int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic random_op(int unsigned cap);
		op_row_t row;
		int unsigned pick, tries, other;
		row.typed = 0;
		row.res = '0;
		row.node = NODE_W'($urandom_range(0, NODES - 1));
		row.hash = $urandom;
		row.key = $urandom;
		pick = $urandom_range(0, 99);
		if (live_nodes.size() != 0)
			other = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
		if (pick < 45 && live_nodes.size() < cap) begin
			row.kind = KIND_INSERT;
			tries = 0;
			while (in_table[row.node] && tries < 64) begin
				row.node = NODE_W'($urandom_range(0, NODES - 1));
				tries++;
			end
			if (in_table[row.node])
				row.kind = KIND_LOOKUP;
			else if (live_nodes.size() != 0 && $urandom_range(0, 9) < 3) begin
				row.hash = live_hash[other];
				if ($urandom_range(0, 1))
					row.key = live_key[other];
			end
		end else if (pick < 93 && live_nodes.size() != 0) begin
			row.kind = (pick < 72 || pick >= 90) ? KIND_LOOKUP : KIND_POP;
			row.hash = live_hash[other];
			row.key = live_key[other];
			if (pick >= 90)
				row.key = $urandom;
		end else if (pick < 97) begin
			row.kind = $urandom_range(0, 1) ? KIND_LOOKUP : KIND_POP;
		end else begin
			row.kind = KIND_UNUSED;
		end
		send_op(row);
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected transaction: found %0d node %0d count %0d",
					$realtime, found, match_node, entry_count);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (found !== e.found) begin
					$display("%0t found: expected %0d actual %0d", $realtime, e.found, found);
					errors++;
				end
				if (match_node !== e.node) begin
					$display("%0t match_node: expected %0d actual %0d",
						$realtime, e.node, match_node);
					errors++;
				end
				if (entry_count !== e.cnt) begin
					$display("%0t entry_count: expected %0d actual %0d",
						$realtime, e.cnt, entry_count);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, 14);
			if (n != 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	op_row_t dir_rows[19];
	int unsigned phase_lf[7] = '{3, 0, 6, 1, 2, 0, 5};
	int unsigned phase_rw[7] = '{128, 1, 1023, 3, 50, 1023, 7};

	initial begin
		op_row_t row;
		int unsigned cap, victim;
		for (int i = 0; i < 2 * TBL_SLOTS; i++)
			heads[i] = NIL;
		for (int i = 0; i < NODES; i++) begin
			nnext[i] = 0;
			nhash[i] = 0;
			nkey[i] = 0;
			in_table[i] = 0;
		end
		pbank = 0; plive = 0; slive = 0; plg = 2; slg = 0; mslot = 0;
		pcnt = '0; scnt = '0;

		dir_rows[0]  = '{KIND_LOOKUP, 0, 0, 0, 1, '{1'b0, 12'd0, 13'd0}};
		dir_rows[1]  = '{KIND_UNUSED, 4095, '1, '1, 1, '{1'b0, 12'd0, 13'd0}};
		dir_rows[2]  = '{KIND_POP, 0, 0, 0, 1, '{1'b0, 12'd0, 13'd0}};
		dir_rows[3]  = '{KIND_INSERT, 0, 0, 0, 1, '{1'b0, 12'd0, 13'd1}};
		dir_rows[4]  = '{KIND_INSERT, 4095, '1, '1, 1, '{1'b0, 12'd4095, 13'd2}};
		dir_rows[5]  = '{KIND_LOOKUP, 0, '1, '1, 1, '{1'b1, 12'd4095, 13'd2}};
		dir_rows[6]  = '{KIND_INSERT, 5, 0, 0, 1, '{1'b0, 12'd5, 13'd3}};
		dir_rows[7]  = '{KIND_LOOKUP, 0, 0, 0, 1, '{1'b1, 12'd5, 13'd3}};
		dir_rows[8]  = '{KIND_POP, 0, 0, 0, 1, '{1'b1, 12'd5, 13'd2}};
		dir_rows[9]  = '{KIND_LOOKUP, 0, 0, 0, 1, '{1'b1, 12'd0, 13'd2}};
		dir_rows[10] = '{KIND_INSERT, 6, 0, 1, 0, '0};
		dir_rows[11] = '{KIND_INSERT, 7, 4, 0, 0, '0};
		dir_rows[12] = '{KIND_LOOKUP, 0, 4, 0, 0, '0};
		dir_rows[13] = '{KIND_LOOKUP, 0, 0, 1, 0, '0};
		dir_rows[14] = '{KIND_POP, 0, 0, 0, 0, '0};
		dir_rows[15] = '{KIND_POP, 0, '1, '1, 1, '{1'b1, 12'd4095, 13'd2}};
		dir_rows[16] = '{KIND_POP, 0, '1, '1, 1, '{1'b0, 12'd0, 13'd2}};
		dir_rows[17] = '{KIND_UNUSED, 0, 0, 0, 1, '{1'b0, 12'd0, 13'd2}};
		dir_rows[18] = '{KIND_LOOKUP, 0, 1, 0, 1, '{1'b0, 12'd0, 13'd2}};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_op(dir_rows[i]);

		for (int p = 0; p < 7; p++) begin
			if (p != 0) begin
				settle();
				apb_write(REG_LOAD_FACTOR, phase_lf[p]);
				cfg_lf = phase_lf[p];
				apb_write(REG_RESIZE_WORK, phase_rw[p]);
				cfg_rw = phase_rw[p];
			end
			cap = $urandom_range(20, 400);
			for (int i = 0; i < 150; i++) begin
				if (i % 40 == 0)
					burst = ($urandom_range(0, 3) == 0);
				random_op(cap);
			end
		end

		// relink a node that is still in the table, then walk its bucket
		burst = 0;
		if (live_nodes.size() != 0) begin
			victim = live_nodes[0];
			row = '{KIND_INSERT, NODE_W'(victim), live_hash[victim], live_key[victim] + 1,
				0, '0};
			send_op(row);
			row = '{KIND_LOOKUP, 0, live_hash[victim], $urandom, 0, '0};
			send_op(row);
			row = '{KIND_POP, 0, live_hash[victim], live_key[victim], 0, '0};
			send_op(row);
		end

		settle();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
